>>> src/hklru_pkg.sv
// ----------------------------------------------------------------------------
// hklru_pkg
// Shared types and constants of the hashed-key LRU tag directory: hash
// constants, field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package hklru_pkg;

	localparam int unsigned KEY_W  = 64;
	localparam int unsigned SIG_W  = 64;
	localparam int unsigned CX_W   = 16;
	localparam int unsigned CY_W   = 32;
	localparam int unsigned SLOT_W = 6;
	localparam int unsigned HALF_W = 32;

	localparam logic [KEY_W-1:0] GOLDEN_ADD = 64'h9e3779b97f4a7c15;
	localparam logic [KEY_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [KEY_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;
	localparam logic [KEY_W-1:0] ROW_MUL    = 64'h9e3779b185ebca87;

	localparam int unsigned XS_A = 30;
	localparam int unsigned XS_B = 27;
	localparam int unsigned XS_C = 31;

	// multiply phases: three partial products, two accumulate steps, result
	localparam logic [2:0] MUL_PH_LAST = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_R,
		ST_SCAN,
		ST_UPDATE,
		ST_RESULT
	} hklru_state_t;

endpackage

>>> src/hklru_if.sv
// ----------------------------------------------------------------------------
// hklru request / response channels
// Valid/ready channels carrying a lookup request and its directory result.
// ----------------------------------------------------------------------------
interface hklru_req_if import hklru_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [SIG_W-1:0]        context_signature;
	logic [CX_W-1:0]         cell_x;
	logic signed [CY_W-1:0]  cell_y;

	modport source (output valid, context_signature, cell_x, cell_y, input ready);
	modport sink   (input valid, context_signature, cell_x, cell_y, output ready);
endinterface

interface hklru_rsp_if import hklru_pkg::*;;
	logic                valid;
	logic                ready;
	logic                hit;
	logic [SLOT_W-1:0]   slot;
	logic                flushed;
	logic                evicted;
	logic [KEY_W-1:0]    hashed_key;

	modport source (output valid, hit, slot, flushed, evicted, hashed_key, input ready);
	modport sink   (input valid, hit, slot, flushed, evicted, hashed_key, output ready);
endinterface

>>> src/hashed_key_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// hashed_key_lru_cache_tags
// Tag directory of a fully associative cache with LRU replacement, keyed by
// a splitmix hash of a macro cell coordinate pair.
// ----------------------------------------------------------------------------
// usage:
//   req carries context_signature, cell_x, cell_y; rsp returns hit, slot,
//   flushed, evicted and the hashed key, one rsp transaction per request.
//   a signature that differs from the stored one flushes every entry first.
//   timing: one request at a time; req.ready is high only while idle.
//   the hash runs five 64x64 multiplies on one shared 32x32 multiplier,
//   each from three partial products; then the directory scan reads one
//   valid entry per cycle from the tag memory, then an update state writes
//   the entry and a result state loads the rsp register. req.ready rises
//   together with rsp.valid, so the next request can be accepted while
//   the response still waits for rsp.ready.
//   valid entries always form a prefix of the memory, so a fill count
//   stands in for per-entry valid bits and no clearing pass is needed.
//   reset empties the directory, zeroes signature and use tick at once.
//   a stalled rsp holds its result; a finished lookup waits in the result
//   state until the output register is free.
// ----------------------------------------------------------------------------
module hashed_key_lru_cache_tags import hklru_pkg::*; #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	hklru_req_if.sink    req,
	hklru_rsp_if.source  rsp
);

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

	hklru_state_t state_q, state_d;

	logic [2:0]          ph_q;
	logic                round_q;
	logic [CW-1:0]       fill_q;
	logic [SIG_W-1:0]    sig_q;
	logic [KEY_W-1:0]    tick_q;
	logic [CW-1:0]       rd_q;
	logic                cmp_v_s1;
	logic [AW-1:0]       cmp_idx_s1;
	logic                rsp_valid_q;

	// hash datapath
	logic [KEY_W-1:0]    ma_q;
	logic [KEY_W-1:0]    acc_q;
	logic [KEY_W-1:0]    prod_s1;
	logic [KEY_W-1:0]    k_q;
	logic [KEY_W-1:0]    key_q;
	logic [CY_W-1:0]     cy_q;

	// scan and result
	logic                hit_q;
	logic [AW-1:0]       hidx_q;
	logic                minv_q;
	logic [KEY_W-1:0]    min_q;
	logic [AW-1:0]       lru_q;
	logic                flushed_q;
	logic                evicted_q;
	logic [AW-1:0]       slot_q;

	logic [2*KEY_W-1:0]  entry_q [ENTRIES];
	logic [2*KEY_W-1:0]  rdata_s1;

	logic                accept;
	logic                mul_done;
	logic                full;
	logic [KEY_W-1:0]    mul_const;
	logic [HALF_W-1:0]   mul_a_half;
	logic [HALF_W-1:0]   mul_b_half;
	logic [KEY_W-1:0]    mul_p;
	logic [AW-1:0]       upd_idx;
	logic                mem_we;
	logic [KEY_W-1:0]    seed;
	logic [KEY_W-1:0]    row_mix;
	logic [KEY_W-1:0]    fin;
	logic [KEY_W-1:0]    rd_key;
	logic [KEY_W-1:0]    rd_use;

	assign accept     = req.valid && req.ready;
	assign mul_done   = (ph_q == MUL_PH_LAST);
	assign full       = (fill_q == FULL_CNT);
	assign req.ready  = (state_q == ST_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rd_key     = rdata_s1[2*KEY_W-1:KEY_W];
	assign rd_use     = rdata_s1[KEY_W-1:0];

	assign seed    = {{(KEY_W-CX_W){1'b0}}, req.cell_x} + GOLDEN_ADD;
	assign row_mix = (k_q ^ acc_q) + GOLDEN_ADD;
	assign fin     = acc_q ^ (acc_q >> XS_C);

	// shared 32x32 multiplier: lo*lo, lo*hi, hi*lo
	assign mul_a_half = (ph_q == 3'd2) ? ma_q[KEY_W-1:HALF_W] : ma_q[HALF_W-1:0];
	assign mul_b_half = (ph_q == 3'd1) ? mul_const[KEY_W-1:HALF_W] : mul_const[HALF_W-1:0];
	assign mul_p      = KEY_W'(mul_a_half) * KEY_W'(mul_b_half);

	always_comb begin
		state_d   = state_q;
		mul_const = MIX_MUL_A;
		mem_we    = 1'b0;
		if (hit_q) begin
			upd_idx = hidx_q;
		end else if (full) begin
			upd_idx = lru_q;
		end else begin
			upd_idx = fill_q[AW-1:0];
		end
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				mul_const = MIX_MUL_A;
				if (mul_done) begin
					state_d = ST_MUL_B;
				end
			end
			ST_MUL_B: begin
				mul_const = MIX_MUL_B;
				if (mul_done) begin
					state_d = round_q ? ST_SCAN : ST_MUL_R;
				end
			end
			ST_MUL_R: begin
				mul_const = ROW_MUL;
				if (mul_done) begin
					state_d = ST_MUL_A;
				end
			end
			ST_SCAN: begin
				if (rd_q == fill_q && !cmp_v_s1) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				mem_we  = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= '0;
			round_q     <= 1'b0;
			fill_q      <= '0;
			sig_q       <= '0;
			tick_q      <= '0;
			rd_q        <= '0;
			cmp_v_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == ST_MUL_A || state_q == ST_MUL_B || state_q == ST_MUL_R) begin
				ph_q <= mul_done ? 3'd0 : ph_q + 3'd1;
			end else begin
				ph_q <= '0;
			end

			if (accept) begin
				round_q  <= 1'b0;
				rd_q     <= '0;
				cmp_v_s1 <= 1'b0;
				if (req.context_signature != sig_q) begin
					sig_q  <= req.context_signature;
					tick_q <= KEY_W'(1);
					fill_q <= '0;
				end else begin
					tick_q <= tick_q + KEY_W'(1);
				end
			end

			if (state_q == ST_MUL_R && mul_done) begin
				round_q <= 1'b1;
			end

			if (state_q == ST_SCAN) begin
				if (rd_q < fill_q) begin
					rd_q     <= rd_q + CW'(1);
					cmp_v_s1 <= 1'b1;
				end else begin
					cmp_v_s1 <= 1'b0;
				end
			end

			if (state_q == ST_UPDATE && !hit_q && !full) begin
				fill_q <= fill_q + CW'(1);
			end

			if (state_q == ST_RESULT && state_d == ST_IDLE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1    <= mul_p;
		cmp_idx_s1 <= rd_q[AW-1:0];

		if (accept) begin
			ma_q      <= seed ^ (seed >> XS_A);
			cy_q      <= req.cell_y;
			hit_q     <= 1'b0;
			minv_q    <= 1'b0;
			flushed_q <= (req.context_signature != sig_q);
		end

		if (state_q == ST_MUL_A || state_q == ST_MUL_B || state_q == ST_MUL_R) begin
			case (ph_q)
				3'd1: acc_q <= prod_s1;
				3'd2, 3'd3: acc_q <= acc_q + {prod_s1[HALF_W-1:0], {HALF_W{1'b0}}};
				default: ;
			endcase
			if (mul_done) begin
				case (state_q)
					ST_MUL_A: ma_q <= acc_q ^ (acc_q >> XS_B);
					ST_MUL_B: begin
						if (round_q) begin
							key_q <= fin;
						end else begin
							k_q  <= fin;
							ma_q <= {{(KEY_W-CY_W){cy_q[CY_W-1]}}, cy_q};
						end
					end
					ST_MUL_R: ma_q <= row_mix ^ (row_mix >> XS_A);
					default: ;
				endcase
			end
		end

		if (state_q == ST_SCAN && cmp_v_s1) begin
			if (!hit_q && rd_key == key_q) begin
				hit_q  <= 1'b1;
				hidx_q <= cmp_idx_s1;
			end
			// strict less keeps the lowest index on ties
			if (!minv_q || rd_use < min_q) begin
				minv_q <= 1'b1;
				min_q  <= rd_use;
				lru_q  <= cmp_idx_s1;
			end
		end

		if (state_q == ST_UPDATE) begin
			slot_q    <= upd_idx;
			evicted_q <= !hit_q && full;
		end

		if (state_q == ST_RESULT && state_d == ST_IDLE) begin
			rsp.hit        <= hit_q;
			rsp.slot       <= SLOT_W'(slot_q);
			rsp.flushed    <= flushed_q;
			rsp.evicted    <= evicted_q;
			rsp.hashed_key <= key_q;
		end
	end

	// tag memory: {key, last use}, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_q[upd_idx] <= {key_q, tick_q};
		end
		rdata_s1 <= entry_q[rd_q[AW-1:0]];
	end

endmodule

>>> tb/tb_hashed_key_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// tb_hashed_key_lru_cache_tags
// Self-checking bench for the hashed-key LRU tag directory. A short table of
// lookups covers the field extremes, hits, flushes and signature zero after
// reset. Random sessions follow: each keeps one signature and draws cells from
// a pool smaller than, equal to or larger than the directory, so hits, fills
// and LRU evictions all occur. Every response transaction is compared per
// field with the oldest prediction of a bench-side directory model.
// ----------------------------------------------------------------------------
module tb_hashed_key_lru_cache_tags;
	import hklru_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRY_COUNT  = 64;
	localparam int DIRECTED_N   = 16;
	localparam int RANDOM_ITEMS = 1100;
	localparam int TOTAL_ITEMS  = DIRECTED_N + RANDOM_ITEMS;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 150;

	typedef struct packed {
		logic [SIG_W-1:0]       sig;
		logic [CX_W-1:0]        cx;
		logic signed [CY_W-1:0] cy;
	} lookup_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              flushed;
		logic              evicted;
		logic [KEY_W-1:0]  key;
	} dir_result_t;

	typedef struct packed {
		logic [SIG_W-1:0]       sig;
		logic [CX_W-1:0]        cx;
		logic signed [CY_W-1:0] cy;
		logic                   fixed;
		logic                   hit;
		logic [SLOT_W-1:0]      slot;
		logic                   flushed;
		logic                   evicted;
	} dir_row_t;

	// fixed rows carry hit, slot, flushed, evicted; the key always comes from the model
	dir_row_t directed_rows [DIRECTED_N] = '{
		'{64'h0, 16'h0000, 32'sh00000000, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
		'{64'h0, 16'h0000, 32'sh00000000, 1'b1, 1'b1, 6'd0, 1'b0, 1'b0},
		'{64'h0, 16'hFFFF, 32'sh7FFFFFFF, 1'b1, 1'b0, 6'd1, 1'b0, 1'b0},
		'{64'h0, 16'h0000, 32'sh80000000, 1'b1, 1'b0, 6'd2, 1'b0, 1'b0},
		'{64'h0, 16'hFFFF, 32'shFFFFFFFF, 1'b1, 1'b0, 6'd3, 1'b0, 1'b0},
		'{64'h0, 16'hFFFF, 32'sh7FFFFFFF, 1'b1, 1'b1, 6'd1, 1'b0, 1'b0},
		'{64'hFFFFFFFFFFFFFFFF, 16'h0000, 32'sh00000000, 1'b1, 1'b0, 6'd0, 1'b1, 1'b0},
		'{64'hFFFFFFFFFFFFFFFF, 16'h0000, 32'sh00000000, 1'b1, 1'b1, 6'd0, 1'b0, 1'b0},
		'{64'hFFFFFFFFFFFFFFFF, 16'h0001, 32'sh00000001, 1'b1, 1'b0, 6'd1, 1'b0, 1'b0},
		'{64'h0, 16'h0001, 32'sh00000001, 1'b1, 1'b0, 6'd0, 1'b1, 1'b0},
		'{64'h5555555555555555, 16'hAAAA, 32'sh55555555, 1'b1, 1'b0, 6'd0, 1'b1, 1'b0},
		'{64'hAAAAAAAAAAAAAAAA, 16'h5555, 32'shAAAAAAAA, 1'b1, 1'b0, 6'd0, 1'b1, 1'b0},
		'{64'hAAAAAAAAAAAAAAAA, 16'h5555, 32'shAAAAAAAA, 1'b1, 1'b1, 6'd0, 1'b0, 1'b0},
		'{64'hAAAAAAAAAAAAAAAA, 16'h8000, 32'sh00000001, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{64'hAAAAAAAAAAAAAAAA, 16'h0001, 32'shFFFFFFFE, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
		'{64'h8000000000000000, 16'h1234, 32'shDEADBEEF, 1'b1, 1'b0, 6'd0, 1'b1, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	hklru_req_if req_ch ();
	hklru_rsp_if rsp_ch ();

	hashed_key_lru_cache_tags #(
		.ENTRIES (ENTRY_COUNT)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #4 clk = ~clk;

	// bench copy of the directory
	bit   [ENTRY_COUNT-1:0] dir_valid = '0;
	logic [KEY_W-1:0]       dir_key      [ENTRY_COUNT];
	logic [63:0]            dir_last_use [ENTRY_COUNT];
	logic [SIG_W-1:0]       dir_sig  = '0;
	logic [63:0]            dir_tick = '0;

	dir_result_t pending_results [$];
	int          mismatches  = 0;
	int          items_sent  = 0;
	int          send_pct    = 0;
	int          recv_pct    = 0;
	int          idle_cycles = 0;

	function automatic void enqueue_result(input dir_result_t res);
		pending_results.insert(pending_results.size(), res);
	endfunction

	function automatic logic [63:0] splitmix(input logic [63:0] z);
		logic [63:0] t;
		t = z + GOLDEN_ADD;
		t = (t ^ (t >> XS_A)) * MIX_MUL_A;
		t = (t ^ (t >> XS_B)) * MIX_MUL_B;
		return t ^ (t >> XS_C);
	endfunction

	function automatic dir_result_t lookup_predict(input lookup_t item);
		logic [63:0] row_ext;
		logic [63:0] oldest;
		dir_result_t res;
		int          idx;
		int          pick;
		row_ext = {{32{item.cy[31]}}, item.cy};
		res = '0;
		res.key = splitmix(splitmix({48'd0, item.cx}) ^ (row_ext * ROW_MUL));
		if (item.sig != dir_sig) begin
			dir_sig = item.sig;
			dir_tick = '0;
			dir_valid = '0;
			res.flushed = 1'b1;
		end
		dir_tick = dir_tick + 64'd1;
		pick = -1;
		for (idx = 0; idx < ENTRY_COUNT; idx++) begin
			if (pick < 0 && dir_valid[idx] && dir_key[idx] == res.key)
				pick = idx;
		end
		if (pick >= 0) begin
			res.hit = 1'b1;
		end else begin
			for (idx = 0; idx < ENTRY_COUNT; idx++) begin
				if (pick < 0 && !dir_valid[idx])
					pick = idx;
			end
			if (pick < 0) begin
				// full: oldest last-use wins, lowest index on a tie
				pick = 0;
				oldest = dir_last_use[0];
				for (idx = 1; idx < ENTRY_COUNT; idx++) begin
					if (dir_last_use[idx] < oldest) begin
						oldest = dir_last_use[idx];
						pick = idx;
					end
				end
				res.evicted = 1'b1;
			end
			dir_valid[pick] = 1'b1;
			dir_key[pick] = res.key;
		end
		dir_last_use[pick] = dir_tick;
		res.slot = SLOT_W'(pick);
		return res;
	endfunction

	// called just after a rising edge; returns at the edge the transaction completes
	task automatic drive_lookup(input lookup_t item);
		int gap;
		if (items_sent < TOTAL_ITEMS / 3) begin
			send_pct = 31;
			recv_pct = 68;
		end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
			send_pct = 68;
			recv_pct = 31;
		end else begin
			send_pct = 0;
			recv_pct = 0;
		end
		if (send_pct != 0 && $urandom_range(99) < send_pct) begin
			gap = ($urandom_range(7) == 0) ? $urandom_range(9, 120) : $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.context_signature <= item.sig;
		req_ch.cell_x <= item.cx;
		req_ch.cell_y <= item.cy;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_pct);
		end
	end

	always @(posedge clk) begin
		dir_result_t exp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: response transaction with nothing pending: key %h",
						$realtime, rsp_ch.hashed_key);
				mismatches++;
			end else begin
				exp = pending_results.pop_front();
				if (rsp_ch.hit !== exp.hit || rsp_ch.slot !== exp.slot
						|| rsp_ch.flushed !== exp.flushed || rsp_ch.evicted !== exp.evicted
						|| rsp_ch.hashed_key !== exp.key) begin
					// fields in order: hit, slot, flushed, evicted, key
					if (mismatches < 10)
						$display("%0t: mismatch exp %b %0d %b %b %h / got %b %0d %b %b %h",
							$realtime,
							exp.hit, exp.slot, exp.flushed, exp.evicted, exp.key,
							rsp_ch.hit, rsp_ch.slot, rsp_ch.flushed, rsp_ch.evicted,
							rsp_ch.hashed_key);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		lookup_t     pool [128];
		lookup_t     item;
		dir_row_t    row;
		dir_result_t exp;
		logic [SIG_W-1:0] session_sig;
		int pool_size;
		int run_len;
		int done;
		int n;
		int j;
		int r;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.context_signature <= '0;
		req_ch.cell_x <= '0;
		req_ch.cell_y <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < DIRECTED_N; n++) begin
			row = directed_rows[n];
			item = '{row.sig, row.cx, row.cy};
			drive_lookup(item);
			exp = lookup_predict(item);
			if (row.fixed) begin
				exp.hit = row.hit;
				exp.slot = row.slot;
				exp.flushed = row.flushed;
				exp.evicted = row.evicted;
			end
			enqueue_result(exp);
		end

		// random sessions: one signature, a pool of 6 to 128 cells around the directory size
		done = 0;
		session_sig = dir_sig;
		while (done < RANDOM_ITEMS) begin
			case ($urandom_range(4))
				0, 1: session_sig = {$urandom, $urandom};
				2: ; // keep the signature, old entries stay live
				3: session_sig = $urandom_range(1) ? '1 : '0;
				default: session_sig = 64'($urandom_range(15));
			endcase
			case ($urandom_range(5))
				0: pool_size = 6;
				1: pool_size = 40;
				2: pool_size = 64;
				3: pool_size = 65;
				4: pool_size = 90;
				default: pool_size = 128;
			endcase
			for (j = 0; j < pool_size; j++) begin
				pool[j].sig = session_sig;
				pool[j].cx = 16'($urandom);
				pool[j].cy = 32'($urandom);
				if ($urandom_range(7) == 0)
					pool[j].cx = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				if ($urandom_range(7) == 0)
					pool[j].cy = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			end
			run_len = $urandom_range(40, 160);
			if (run_len > RANDOM_ITEMS - done)
				run_len = RANDOM_ITEMS - done;
			for (n = 0; n < run_len; n++) begin
				r = $urandom_range(99);
				if (r < 6) begin
					item = '{session_sig, 16'($urandom), 32'($urandom)};
				end else if (r < 8) begin
					// stray signature breaks the session with a flush
					item = '{{$urandom, $urandom}, 16'($urandom), 32'($urandom)};
				end else begin
					item = pool[$urandom_range(pool_size - 1)];
				end
				drive_lookup(item);
				enqueue_result(lookup_predict(item));
				done++;
			end
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
